### rtl/utf8_to_utf16_stream_decoder_core_macros.svh
// Assertion macros for the UTF-8 to UTF-16 stream decoder.
`ifndef UTF8_TO_UTF16_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_CORE_MACROS_SVH

// Checked at every clock edge outside reset.
`define U8U16_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/u8u16_pkg.sv
// Types and constants for the UTF-8 to UTF-16 stream decoder.
package u8u16_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_BOM   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT = 1'd1;

   localparam logic [15:0] REPLACEMENT_RESET = 16'hFFFD;

   localparam logic [7:0] BOM_BYTE0 = 8'hEF;
   localparam logic [7:0] BOM_BYTE1 = 8'hBB;
   localparam logic [7:0] BOM_BYTE2 = 8'hBF;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_BOM  = 2'd1;
   localparam logic [1:0] STATUS_BAD_UTF8 = 2'd2;

   localparam logic [20:0] CP_MIN_2BYTE = 21'h00080;
   localparam logic [20:0] CP_MIN_3BYTE = 21'h00800;
   localparam logic [20:0] CP_MIN_4BYTE = 21'h10000;
   localparam logic [20:0] CP_MAX       = 21'h10FFFF;
   localparam logic [20:0] SURR_LO      = 21'h0D800;
   localparam logic [20:0] SURR_HI      = 21'h0DFFF;

   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

   typedef struct packed {
      logic [15:0] first_unit;
      logic [15:0] second_unit;
      logic [1:0]  unit_count;
      logic [1:0]  status;
   } result_type;

endpackage

### rtl/utf8_to_utf16_stream_decoder_core.sv
// UTF-8 to UTF-16 stream decoder: one byte per beat, zero or one result per byte.
// A result appears on the rsp_ channel the cycle after its byte is accepted, held
// in a single output register; req_ready is high while that register is empty or
// being drained in the same cycle, so throughput is one byte per cycle while
// rsp_ready stays high. Decode state, BOM detection and the completion checks are
// all resolved in the accepting cycle.
`include "utf8_to_utf16_stream_decoder_core_macros.svh"

module utf8_to_utf16_stream_decoder_core
   import u8u16_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_stream_start,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_first_unit,
   output logic [15:0]            rsp_second_unit,
   output logic [1:0]             rsp_unit_count,
   output logic [1:0]             rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic        strip_bom_ff;
   logic [15:0] replacement_ff;

   logic [1:0]  bom_phase_ff, bom_phase_in;
   logic        bom_window_ff, bom_window_in;
   logic [1:0]  trail_ff, trail_in;
   logic [1:0]  seq_len_ff, seq_len_in;
   logic [20:0] acc_ff, acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [1:0]  cur_phase;
   logic        cur_window;
   logic [1:0]  cur_trail;
   logic [1:0]  cur_len;
   logic [20:0] cur_acc;
   logic [7:0]  b;

   logic [20:0] cp;
   logic [20:0] cp_lower;
   logic [19:0] cp_off;
   logic        fin_valid;
   result_type  fin_res;
   logic        res_valid;
   result_type  res;

   logic        rsp_err_beat;
   logic        rsp_ok_beat;
   logic        rsp_pair_beat;
   logic        units_zero;
   logic        units_present;
   logic        pair_tags;
   logic        seq_open;
   logic        trail_fits;
   logic        bom_busy;
   logic        bom_ok;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign b         = req_data_byte;

   assign cur_phase  = req_stream_start ? 2'd0 : bom_phase_ff;
   assign cur_window = req_stream_start ? 1'b1 : bom_window_ff;
   assign cur_trail  = req_stream_start ? 2'd0 : trail_ff;
   assign cur_len    = req_stream_start ? 2'd0 : seq_len_ff;
   assign cur_acc    = req_stream_start ? 21'd0 : acc_ff;

   // completion of a sequence on the last continuation byte
   assign cp     = {cur_acc[14:0], b[5:0]};
   assign cp_off = 20'(cp - CP_MIN_4BYTE);

   always_comb begin
      unique case (cur_len)
         2'd1:    cp_lower = CP_MIN_2BYTE;
         2'd2:    cp_lower = CP_MIN_3BYTE;
         default: cp_lower = CP_MIN_4BYTE;
      endcase
   end

   always_comb begin
      fin_valid = 1'b1;
      fin_res   = '0;
      if (cp < cp_lower || cp > CP_MAX) begin
         fin_res.status = STATUS_BAD_UTF8;
      end else if (cp >= SURR_LO && cp <= SURR_HI) begin
         fin_res.first_unit = replacement_ff;
         fin_res.unit_count = 2'd1;
      end else if (cp < CP_MIN_4BYTE) begin
         fin_res.first_unit = cp[15:0];
         fin_res.unit_count = 2'd1;
      end else begin
         fin_res.first_unit  = {HIGH_SURR_TAG, cp_off[19:10]};
         fin_res.second_unit = {LOW_SURR_TAG, cp_off[9:0]};
         fin_res.unit_count  = 2'd2;
      end
   end

   always_comb begin
      bom_phase_in  = bom_phase_ff;
      bom_window_in = bom_window_ff;
      trail_in      = trail_ff;
      seq_len_in    = seq_len_ff;
      acc_in        = acc_ff;
      res_valid     = 1'b0;
      res           = '0;
      if (accept) begin
         bom_phase_in  = 2'd0;
         bom_window_in = 1'b0;
         trail_in      = cur_trail;
         seq_len_in    = cur_len;
         acc_in        = cur_acc;
         if (cur_window && strip_bom_ff && cur_phase == 2'd0 && b == BOM_BYTE0) begin
            bom_phase_in  = 2'd1;
            bom_window_in = 1'b1;
         end else if (cur_window && strip_bom_ff && cur_phase == 2'd1) begin
            if (b == BOM_BYTE1) begin
               bom_phase_in  = 2'd2;
               bom_window_in = 1'b1;
            end else begin
               res_valid  = 1'b1;
               res.status = STATUS_BAD_BOM;
            end
         end else if (cur_window && strip_bom_ff && cur_phase != 2'd0) begin
            if (b != BOM_BYTE2) begin
               res_valid  = 1'b1;
               res.status = STATUS_BAD_BOM;
            end
         end else if (cur_trail != 2'd0) begin
            if (b[7:6] != 2'b10) begin
               trail_in   = 2'd0;
               seq_len_in = 2'd0;
               acc_in     = '0;
               res_valid  = 1'b1;
               res.status = STATUS_BAD_UTF8;
            end else if (cur_trail == 2'd1) begin
               trail_in   = 2'd0;
               seq_len_in = 2'd0;
               acc_in     = '0;
               res_valid  = fin_valid;
               res        = fin_res;
            end else begin
               trail_in = cur_trail - 2'd1;
               acc_in   = cp;
            end
         end else if (b[7] == 1'b0) begin
            res_valid      = 1'b1;
            res.first_unit = {8'd0, b};
            res.unit_count = 2'd1;
         end else if (b[7:5] == 3'b110) begin
            acc_in     = {16'd0, b[4:0]};
            seq_len_in = 2'd1;
            trail_in   = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            acc_in     = {17'd0, b[3:0]};
            seq_len_in = 2'd2;
            trail_in   = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            acc_in     = {18'd0, b[2:0]};
            seq_len_in = 2'd3;
            trail_in   = 2'd3;
         end else begin
            trail_in   = 2'd0;
            seq_len_in = 2'd0;
            acc_in     = '0;
            res_valid  = 1'b1;
            res.status = STATUS_BAD_UTF8;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_bom_ff   <= 1'b0;
         replacement_ff <= REPLACEMENT_RESET;
         bom_phase_ff   <= 2'd0;
         bom_window_ff  <= 1'b1;
         trail_ff       <= 2'd0;
         seq_len_ff     <= 2'd0;
         acc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_STRIP_BOM:   strip_bom_ff   <= csr_wdata[0];
               CSR_REPLACEMENT: replacement_ff <= csr_wdata;
               default:         ;
            endcase
         end
         bom_phase_ff  <= bom_phase_in;
         bom_window_ff <= bom_window_in;
         trail_ff      <= trail_in;
         seq_len_ff    <= seq_len_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_unit  = rsp_data_ff.first_unit;
   assign rsp_second_unit = rsp_data_ff.second_unit;
   assign rsp_unit_count  = rsp_data_ff.unit_count;
   assign rsp_status      = rsp_data_ff.status;

   assign rsp_err_beat  = rsp_valid_ff && rsp_data_ff.status != STATUS_OK;
   assign rsp_ok_beat   = rsp_valid_ff && rsp_data_ff.status == STATUS_OK;
   assign rsp_pair_beat = rsp_valid_ff && rsp_data_ff.unit_count == 2'd2;
   assign units_zero    = rsp_data_ff.unit_count == 2'd0 && rsp_data_ff.first_unit == 16'd0
                          && rsp_data_ff.second_unit == 16'd0;
   assign units_present = rsp_data_ff.unit_count == 2'd1 || rsp_data_ff.unit_count == 2'd2;
   assign pair_tags     = rsp_data_ff.first_unit[15:10] == HIGH_SURR_TAG
                          && rsp_data_ff.second_unit[15:10] == LOW_SURR_TAG;
   assign seq_open      = trail_ff != 2'd0;
   assign trail_fits    = seq_len_ff != 2'd0 && trail_ff <= seq_len_ff;
   assign bom_busy      = bom_phase_ff != 2'd0;
   assign bom_ok        = !seq_open && bom_window_ff;

   `U8U16_ASSERT(a_err_zero, clock, reset, rsp_err_beat |-> units_zero, "error beat carries units")
   `U8U16_ASSERT(a_ok_units, clock, reset, rsp_ok_beat |-> units_present, "ok beat without units")
   `U8U16_ASSERT(a_pair_form, clock, reset, rsp_pair_beat |-> pair_tags, "malformed surrogate pair")
   `U8U16_ASSERT(a_trail_len, clock, reset, seq_open |-> trail_fits, "trail count exceeds length")
   `U8U16_ASSERT(a_bom_no_seq, clock, reset, bom_busy |-> bom_ok, "BOM match during a sequence")

endmodule
